// ----- rtl/iphc_pkg.sv -----
`default_nettype none
package iphc_pkg;

	// Input item kinds.
	localparam logic IPHC_MODE_HEADER  = 1'b0;
	localparam logic IPHC_MODE_PAYLOAD = 1'b1;

	// Payload byte counts; any count above one adds the full word.
	localparam logic [1:0] IPHC_BC_NONE = 2'd0;
	localparam logic [1:0] IPHC_BC_ODD  = 2'd1;

	// Pseudo-header: 16 address words, 2 length words, 1 next-header word.
	localparam int IPHC_HDR_WORDS = 19;
	localparam int IPHC_L2_WORDS  = (IPHC_HDR_WORDS + 1) / 2;
	localparam int IPHC_L3_WORDS  = (IPHC_L2_WORDS + 1) / 2;
	localparam int IPHC_L4_WORDS  = (IPHC_L3_WORDS + 1) / 2;
	localparam int IPHC_L5_WORDS  = (IPHC_L4_WORDS + 1) / 2;

	localparam int IPHC_QUEUE_DEPTH = 4;

	// One classified request for the accumulator.
	typedef struct packed {
		logic        restart;
		logic        last;
		logic [15:0] word;
	} iphc_op_t;

	// 16-bit ones-complement add with end-around carry.
	function automatic logic [15:0] iphc_eac(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/iphc_if.sv -----
`default_nettype none
interface iphc_in_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [63:0] source_high;
	logic [63:0] source_low;
	logic [63:0] destination_high;
	logic [63:0] destination_low;
	logic [31:0] upper_length;
	logic [7:0]  protocol_number;
	logic [15:0] data_word;
	logic [1:0]  byte_count;
	logic        last;

	modport source (
		output valid, mode, source_high, source_low, destination_high, destination_low,
		output upper_length, protocol_number, data_word, byte_count, last,
		input  ready
	);
	modport sink (
		input  valid, mode, source_high, source_low, destination_high, destination_low,
		input  upper_length, protocol_number, data_word, byte_count, last,
		output ready
	);
endinterface

interface iphc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;

	modport source (output valid, checksum, input ready);
	modport sink (input valid, checksum, output ready);
endinterface
`default_nettype wire

// ----- rtl/iphc_front.sv -----
`default_nettype none
module iphc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	iphc_in_if.sink               item,
	output iphc_pkg::iphc_op_t    op,
	output logic                  op_valid,
	input  wire logic             op_ready
);
	import iphc_pkg::*;

	logic        advance;
	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic        restart_s1, restart_s2, restart_s3, restart_s4, restart_s5;
	logic        last_s1, last_s2, last_s3, last_s4, last_s5;
	logic [15:0] words      [IPHC_HDR_WORDS];
	logic [15:0] words_s1   [IPHC_HDR_WORDS];
	logic [15:0] l2         [IPHC_L2_WORDS];
	logic [15:0] words_s2   [IPHC_L2_WORDS];
	logic [15:0] l3         [IPHC_L3_WORDS];
	logic [15:0] words_s3   [IPHC_L3_WORDS];
	logic [15:0] l4         [IPHC_L4_WORDS];
	logic [15:0] words_s4   [IPHC_L4_WORDS];
	logic [15:0] l5         [IPHC_L5_WORDS];
	logic [15:0] words_s5   [IPHC_L5_WORDS];
	logic [15:0] payload;

	// The whole reduction pipeline moves together; it halts only when its
	// tail holds a request that the queue cannot take.
	assign advance    = !valid_s5 || op_ready;
	assign item.ready = advance;

	always_comb begin
		unique case (item.byte_count)
			IPHC_BC_NONE: payload = 16'h0000;
			IPHC_BC_ODD:  payload = {item.data_word[15:8], 8'h00};
			default:      payload = item.data_word;
		endcase
	end

	// A payload item becomes a header-shaped word set with only word 0 possibly nonzero,
	// so both kinds share the same reduction tree.
	always_comb begin
		for (int i = 0; i < IPHC_HDR_WORDS; i++) begin
			words[i] = 16'h0000;
		end
		if (item.mode == IPHC_MODE_HEADER) begin
			for (int k = 0; k < 4; k++) begin
				words[k]      = item.source_high[63 - 16*k -: 16];
				words[4 + k]  = item.source_low[63 - 16*k -: 16];
				words[8 + k]  = item.destination_high[63 - 16*k -: 16];
				words[12 + k] = item.destination_low[63 - 16*k -: 16];
			end
			words[16] = item.upper_length[31:16];
			words[17] = item.upper_length[15:0];
			words[18] = {8'h00, item.protocol_number};
		end else begin
			words[0] = payload;
		end
	end

	always_comb begin
		for (int i = 0; i < IPHC_L2_WORDS; i++) begin
			if (2*i + 1 < IPHC_HDR_WORDS) l2[i] = iphc_eac(words_s1[2*i], words_s1[2*i + 1]);
			else l2[i] = words_s1[2*i];
		end
		for (int i = 0; i < IPHC_L3_WORDS; i++) begin
			if (2*i + 1 < IPHC_L2_WORDS) l3[i] = iphc_eac(words_s2[2*i], words_s2[2*i + 1]);
			else l3[i] = words_s2[2*i];
		end
		for (int i = 0; i < IPHC_L4_WORDS; i++) begin
			if (2*i + 1 < IPHC_L3_WORDS) l4[i] = iphc_eac(words_s3[2*i], words_s3[2*i + 1]);
			else l4[i] = words_s3[2*i];
		end
		for (int i = 0; i < IPHC_L5_WORDS; i++) begin
			if (2*i + 1 < IPHC_L4_WORDS) l5[i] = iphc_eac(words_s4[2*i], words_s4[2*i + 1]);
			else l5[i] = words_s4[2*i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= item.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			restart_s1 <= (item.mode == IPHC_MODE_HEADER);
			last_s1    <= item.last;
			words_s1   <= words;
			restart_s2 <= restart_s1;
			last_s2    <= last_s1;
			words_s2   <= l2;
			restart_s3 <= restart_s2;
			last_s3    <= last_s2;
			words_s3   <= l3;
			restart_s4 <= restart_s3;
			last_s4    <= last_s3;
			words_s4   <= l4;
			restart_s5 <= restart_s4;
			last_s5    <= last_s4;
			words_s5   <= l5;
		end
	end

	assign op_valid   = valid_s5;
	assign op.restart = restart_s5;
	assign op.last    = last_s5;
	assign op.word    = iphc_eac(words_s5[0], words_s5[IPHC_L5_WORDS - 1]);

endmodule
`default_nettype wire

// ----- rtl/iphc_queue.sv -----
`default_nettype none
module iphc_queue #(
	parameter int QUEUE_DEPTH = iphc_pkg::IPHC_QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire iphc_pkg::iphc_op_t  push_op,
	input  wire logic                push_valid,
	output logic                     push_ready,
	output iphc_pkg::iphc_op_t       pop_op,
	output logic                     pop_valid,
	input  wire logic                pop_ready
);
	import iphc_pkg::*;

	// Depth must be a power of two so the pointers wrap on their own.
	localparam int PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CountW = $clog2(QUEUE_DEPTH + 1);

	iphc_op_t            entries_q [QUEUE_DEPTH];
	logic [PtrW-1:0]     wr_ptr_q;
	logic [PtrW-1:0]     rd_ptr_q;
	logic [CountW-1:0]   count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != CountW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_op     = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PtrW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
			if (push && !pop) count_q <= count_q + CountW'(1);
			else if (pop && !push) count_q <= count_q - CountW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entries_q[wr_ptr_q] <= push_op;
	end

endmodule
`default_nettype wire

// ----- rtl/iphc_back.sv -----
`default_nettype none
module iphc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire iphc_pkg::iphc_op_t  op,
	input  wire logic                op_valid,
	output logic                     op_ready,
	iphc_out_if.source               result
);
	import iphc_pkg::*;

	logic [15:0] running_sum_q;
	logic [15:0] sum_next;
	logic        res_valid_q;
	logic [15:0] checksum_q;
	logic        take;

	// A pending result blocks only when it is not being taken this cycle.
	assign op_ready = !res_valid_q || result.ready;
	assign take     = op_valid && op_ready;
	assign sum_next = op.restart ? op.word : iphc_eac(running_sum_q, op.word);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= 16'h0000;
			res_valid_q   <= 1'b0;
		end else begin
			if (take) running_sum_q <= sum_next;
			// A new result replaces one that leaves in the same cycle.
			if (take && op.last) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && op.last) checksum_q <= ~sum_next;
	end

	assign result.valid    = res_valid_q;
	assign result.checksum = checksum_q;

endmodule
`default_nettype wire

// ----- rtl/ipv6_pseudo_header_checksum.sv -----
`default_nettype none
// Channel  | Direction | Contents
// item     | in        | mode, addresses, length, protocol, data_word, byte_count, last
// result   | out       | checksum, one for each item marked last
//
// One item is accepted per cycle while item.ready is high; the result checksum is registered.
// A five-stage adder tree reduces the pseudo-header words, and one end-around-carry
// add per cycle in the accumulator sets the sustained rate while no result is held.
// Reset clears the pipeline, the queue and the running sum; no clearing pass follows.
// A held result stalls the accumulator; a full queue drops item.ready once stage 5 is valid.
module ipv6_pseudo_header_checksum #(
	parameter int QUEUE_DEPTH = iphc_pkg::IPHC_QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	iphc_in_if.sink    item,
	iphc_out_if.source result
);
	import iphc_pkg::*;

	iphc_op_t front_op;
	logic     front_valid;
	logic     front_ready;
	iphc_op_t back_op;
	logic     back_valid;
	logic     back_ready;

	iphc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.op       (front_op),
		.op_valid (front_valid),
		.op_ready (front_ready)
	);

	iphc_queue #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_op    (front_op),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_op     (back_op),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	iphc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (back_op),
		.op_valid (back_valid),
		.op_ready (back_ready),
		.result   (result)
	);

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
	import iphc_pkg::*;

	// Byte counts that the package leaves unnamed.
	localparam logic [1:0] BC_FULL     = 2'd2;
	localparam logic [1:0] BC_OVERSIZE = 2'd3;

	localparam int CYCLE_LIMIT    = 400000;
	localparam int SETTLE_CYCLES  = 20;
	localparam int HOLD_OFF_LEN   = 300;
	localparam int PHASE_REQUESTS = 375;

	typedef struct {
		logic        mode;
		logic [63:0] source_high;
		logic [63:0] source_low;
		logic [63:0] destination_high;
		logic [63:0] destination_low;
		logic [31:0] upper_length;
		logic [7:0]  protocol_number;
		logic [15:0] data_word;
		logic [1:0]  byte_count;
		logic        last;
	} request_t;

	logic clk;
	logic arst_n;

	iphc_in_if  item_ch ();
	iphc_out_if result_ch ();

	ipv6_pseudo_header_checksum dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	logic [15:0] running_ones_sum;
	logic [15:0] expected_checksums[$];
	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_request;
	int error_count = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_top failed");
		$finish;
	end

	function automatic logic [15:0] ones_add(input logic [15:0] acc, input logic [15:0] word);
		logic [31:0] total;
		total = 32'(acc) + 32'(word);
		return total[15:0] + total[31:16];
	endfunction

	function automatic logic [15:0] add_address_words(input logic [15:0] acc,
		input logic [63:0] quad);
		for (int k = 0; k < 4; k++) begin
			acc = ones_add(acc, quad[63 - 16 * k -: 16]);
		end
		return acc;
	endfunction

	task automatic predict_checksum(input request_t r);
		logic [15:0] acc;
		acc = running_ones_sum;
		if (r.mode == IPHC_MODE_HEADER) begin
			acc = 16'h0000;
			acc = add_address_words(acc, r.source_high);
			acc = add_address_words(acc, r.source_low);
			acc = add_address_words(acc, r.destination_high);
			acc = add_address_words(acc, r.destination_low);
			acc = ones_add(acc, r.upper_length[31:16]);
			acc = ones_add(acc, r.upper_length[15:0]);
			acc = ones_add(acc, {8'h00, r.protocol_number});
		end else begin
			case (r.byte_count)
				IPHC_BC_NONE: begin
				end
				IPHC_BC_ODD: begin
					acc = ones_add(acc, {r.data_word[15:8], 8'h00});
				end
				default: begin
					acc = ones_add(acc, r.data_word);
				end
			endcase
		end
		running_ones_sum = acc;
		if (r.last) expected_checksums.push_back(~acc);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic request_t make_header(input logic [63:0] src_hi, input logic [63:0] src_lo,
		input logic [63:0] dst_hi, input logic [63:0] dst_lo, input logic [31:0] len,
		input logic [7:0] proto, input logic last);
		request_t r;
		r.mode             = IPHC_MODE_HEADER;
		r.source_high      = src_hi;
		r.source_low       = src_lo;
		r.destination_high = dst_hi;
		r.destination_low  = dst_lo;
		r.upper_length     = len;
		r.protocol_number  = proto;
		// Payload fields carry junk; a header must ignore them.
		r.data_word        = 16'($urandom);
		r.byte_count       = 2'($urandom);
		r.last             = last;
		return r;
	endfunction

	function automatic request_t random_header(input logic last);
		return make_header(rand64(), rand64(), rand64(), rand64(), $urandom,
			8'($urandom), last);
	endfunction

	function automatic request_t make_payload(input logic [15:0] word, input logic [1:0] count,
		input logic last);
		request_t r;
		r                 = random_header(last);
		r.mode            = IPHC_MODE_PAYLOAD;
		r.data_word       = word;
		r.byte_count      = count;
		return r;
	endfunction

	function automatic request_t random_noise();
		request_t r;
		r            = random_header($urandom_range(3) == 0);
		r.mode       = 1'($urandom);
		return r;
	endfunction

	task automatic send_request(input request_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
		end
		@(negedge clk);
		item_ch.valid            <= 1'b1;
		item_ch.mode             <= r.mode;
		item_ch.source_high      <= r.source_high;
		item_ch.source_low       <= r.source_low;
		item_ch.destination_high <= r.destination_high;
		item_ch.destination_low  <= r.destination_low;
		item_ch.upper_length     <= r.upper_length;
		item_ch.protocol_number  <= r.protocol_number;
		item_ch.data_word        <= r.data_word;
		item_ch.byte_count       <= r.byte_count;
		item_ch.last             <= r.last;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		predict_checksum(r);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		while (expected_checksums.size() != 0) @(posedge clk);
	endtask

	// Result checker: every accepted result is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_checksums.size() == 0) begin
				$display("%0t: unexpected checksum: expected none, got %h",
					$time, result_ch.checksum);
				error_count++;
			end else begin
				if (result_ch.checksum !== expected_checksums[0]) begin
					$display("%0t: checksum mismatch: expected %h, got %h",
						$time, expected_checksums[0], result_ch.checksum);
					error_count++;
				end
				void'(expected_checksums.pop_front());
			end
		end
	end

	// Result side: random stalls, plus a long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_request > 0) begin
				hold_left = hold_off_request;
				hold_off_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Words added before any header land on the reset sum of zero.
	task automatic test_payload_before_header();
		send_request(make_payload(16'h1234, BC_FULL, 1'b0));
		send_request(make_payload(16'hABCD, IPHC_BC_ODD, 1'b0));
		send_request(make_payload(16'hFFFF, IPHC_BC_NONE, 1'b1));
		// After a result the sum stands and keeps growing.
		send_request(make_payload(16'h8001, BC_OVERSIZE, 1'b1));
		wait_drained();
	endtask

	task automatic test_header_extremes();
		send_request(make_header('0, '0, '0, '0, '0, '0, 1'b1));
		send_request(make_header('1, '1, '1, '1, '1, '1, 1'b1));
		send_request(make_header('1, '1, '1, '1, '1, '1, 1'b0));
		send_request(make_payload(16'hFFFF, BC_FULL, 1'b1));
		wait_drained();
	endtask

	task automatic test_byte_counts();
		send_request(random_header(1'b0));
		send_request(make_payload(16'($urandom), IPHC_BC_NONE, 1'b0));
		send_request(make_payload(16'($urandom), IPHC_BC_ODD, 1'b0));
		send_request(make_payload(16'($urandom), BC_OVERSIZE, 1'b0));
		send_request(make_payload(16'hFFFF, BC_FULL, 1'b0));
		send_request(make_payload(16'h00FF, IPHC_BC_ODD, 1'b1));
		wait_drained();
	endtask

	task automatic test_ignored_fields();
		request_t r;
		r = make_header('0, '0, '0, '0, '0, '0, 1'b1);
		r.data_word = 16'hFFFF;
		r.byte_count = BC_FULL;
		send_request(r);
		r = make_payload(16'h0000, BC_FULL, 1'b1);
		r.source_high = '1;
		r.source_low = '1;
		r.destination_high = '1;
		r.destination_low = '1;
		r.upper_length = '1;
		r.protocol_number = '1;
		send_request(r);
		wait_drained();
	endtask

	// Result side blocks for a long stretch while packets keep coming, so the
	// request queue fills and item.ready has to drop.
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_request = HOLD_OFF_LEN;
		for (int n = 0; n < 40; n++) begin
			send_request(random_header($urandom_range(3) != 0));
		end
		wait_drained();
	endtask

	task automatic test_random_packets(input int budget, input int idle_pct, input int stall_pct);
		int sent;
		int words;
		logic [1:0] count;
		bit headless;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(9) == 0) begin
				send_request(random_noise());
				sent++;
			end else begin
				headless = ($urandom_range(19) == 0);
				if ($urandom_range(3) == 0) words = 0;
				else if ($urandom_range(15) == 0) words = $urandom_range(9, 32);
				else words = $urandom_range(1, 8);
				if (!headless || words == 0) begin
					send_request(random_header(words == 0));
					sent++;
				end
				for (int w = 0; w < words; w++) begin
					if (w == words - 1 && $urandom_range(2) == 0) count = IPHC_BC_ODD;
					else if ($urandom_range(7) == 0) count = 2'($urandom);
					else count = BC_FULL;
					send_request(make_payload(16'($urandom), count, w == words - 1));
					sent++;
				end
			end
		end
		wait_drained();
	endtask

	initial begin
		arst_n                   = 1'b0;
		item_ch.valid            = 1'b0;
		item_ch.mode             = IPHC_MODE_HEADER;
		item_ch.source_high      = '0;
		item_ch.source_low       = '0;
		item_ch.destination_high = '0;
		item_ch.destination_low  = '0;
		item_ch.upper_length     = '0;
		item_ch.protocol_number  = '0;
		item_ch.data_word        = '0;
		item_ch.byte_count       = IPHC_BC_NONE;
		item_ch.last             = 1'b0;
		running_ones_sum         = 16'h0000;
		send_idle_pct            = 0;
		recv_stall_pct           = 0;
		hold_off_request         = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_payload_before_header();
		test_header_extremes();
		test_byte_counts();
		test_ignored_fields();
		test_random_packets(PHASE_REQUESTS, 0, 0);
		test_output_backpressure();
		test_random_packets(PHASE_REQUESTS, 51, 0);
		test_random_packets(PHASE_REQUESTS, 0, 51);
		test_random_packets(PHASE_REQUESTS, 22, 22);
		recv_stall_pct = 0;

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end

endmodule

// ----- ipv6_pseudo_header_checksum.f -----
rtl/iphc_pkg.sv
rtl/iphc_if.sv
rtl/iphc_front.sv
rtl/iphc_queue.sv
rtl/iphc_back.sv
rtl/ipv6_pseudo_header_checksum.sv
sim/tb_top.sv
